>>> design/twar_pkg.sv
// ----------------------------------------------------------------------------
// twar_pkg
// Types, state codes and the level averaging function shared by the
// tick-weighted audio resampler.
// ----------------------------------------------------------------------------
package twar_pkg;

	localparam int LEVEL_W = 5;
	localparam int TICK_W  = 6;
	localparam int VOL_W   = 8;
	localparam int SPT_W   = 16;
	localparam int SPAN_W  = SPT_W + TICK_W;
	localparam int REM_W   = SPT_W + 1;
	localparam int PROD_W  = REM_W + VOL_W;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_a;
		logic [LEVEL_W-1:0] level_b;
		logic [LEVEL_W-1:0] level_c;
		logic [TICK_W-1:0]  tick_count;
	} in_t;

	typedef struct packed {
		logic [VOL_W-1:0] sample;
		logic             last;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SPAN  = 5'b00010,
		S_SPLIT = 5'b00100,
		S_WHOLE = 5'b01000,
		S_FRAC  = 5'b10000
	} state_t;

	// Mean of three levels times eight. The sum is at most 93, so multiplying
	// by 171 and dropping nine bits gives the exact truncated third.
	function automatic logic [VOL_W-1:0] level_to_vol(
		input logic [LEVEL_W-1:0] a,
		input logic [LEVEL_W-1:0] b,
		input logic [LEVEL_W-1:0] c
	);
		logic [LEVEL_W+1:0]  sum;
		logic [LEVEL_W+9:0]  scaled;
		logic [LEVEL_W-1:0]  third;
		sum    = {2'b00, a} + {2'b00, b} + {2'b00, c};
		scaled = {8'd0, sum} * (LEVEL_W+10)'(171);
		third  = scaled[LEVEL_W+8:9];
		return {third, 3'b000};
	endfunction

endpackage

>>> design/twar_mul.sv
// ----------------------------------------------------------------------------
// twar_mul
// Shared 17 x 8 unsigned multiplier used by the sequencer for the span and
// for every weighted contribution.
// ----------------------------------------------------------------------------
module twar_mul (
	input  logic [twar_pkg::REM_W-1:0]  op_a,
	input  logic [twar_pkg::VOL_W-1:0]  op_b,
	output logic [twar_pkg::PROD_W-1:0] prod
);
	import twar_pkg::*;

	assign prod = {{VOL_W{1'b0}}, op_a} * {{REM_W{1'b0}}, op_b};

endmodule

>>> design/tick_weighted_audio_resampler_core.sv
// ----------------------------------------------------------------------------
// tick_weighted_audio_resampler_core
// Box-filter resampler: turns tick-weighted channel levels into 8-bit samples.
//
//   Channel   Signals                       Beat
//   input     in_valid/in_ready/in_data     three levels and a tick count
//   output    out_valid/out_ready/out_data  one sample and its last flag
//   config    cfg_we/cfg_data               samples per tick, 0.16 fraction
//
// An input beat that completes no sample passes the span and split states.
// One that completes samples emits one sample per cycle while the output is free,
// all work passing through a single shared multiplier under the sequencer.
// A stalled output holds the sequencer on the pending sample.
// arst_n clears the register, the partial sample and the phase at once.
// ----------------------------------------------------------------------------
module tick_weighted_audio_resampler_core #(
	parameter int MAX_TICKS = 63
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  twar_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output twar_pkg::out_t              out_data,
	input  logic                        cfg_we,
	input  logic [twar_pkg::SPT_W-1:0]  cfg_data
);
	import twar_pkg::*;

	state_t              state_q;
	logic [SPT_W-1:0]    spt_q;
	logic [VOL_W-1:0]    partial_q;
	logic [SPT_W-1:0]    phase_q;
	logic [VOL_W-1:0]    vol_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [SPAN_W-1:0]   span_q;
	logic [TICK_W-1:0]   whole_q;
	logic [SPT_W-1:0]    frac_q;
	logic                out_valid_q;
	out_t                out_q;

	logic [REM_W-1:0]    rem;
	logic [SPAN_W-1:0]   left;
	logic                short_span;
	logic                out_free;
	logic                emit;
	logic                in_fire;
	logic [TICK_W-1:0]   ticks_sat;
	logic [REM_W-1:0]    mul_a;
	logic [VOL_W-1:0]    mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [VOL_W-1:0]    weighed;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	assign ticks_sat  = (in_data.tick_count > TICK_W'(MAX_TICKS)) ?
		TICK_W'(MAX_TICKS) : in_data.tick_count;

	// Remaining fraction of the sample being built; a full sample when phase is 0.
	assign rem        = (REM_W)'(1 << SPT_W) - {1'b0, phase_q};
	assign short_span = span_q < {{(SPAN_W-REM_W){1'b0}}, rem};
	assign left       = span_q - {{(SPAN_W-REM_W){1'b0}}, rem};

	assign emit = ((state_q == S_SPLIT && !short_span) || state_q == S_WHOLE) && out_free;

	always_comb begin
		mul_a = {1'b0, frac_q};
		mul_b = vol_q;
		case (state_q)
			S_SPAN: begin
				mul_a = {1'b0, spt_q};
				mul_b = {{(VOL_W-TICK_W){1'b0}}, ticks_q};
			end
			S_SPLIT: begin
				mul_a = short_span ? span_q[REM_W-1:0] : rem;
				mul_b = vol_q;
			end
			default: begin
				mul_a = {1'b0, frac_q};
				mul_b = vol_q;
			end
		endcase
	end

	twar_mul u_mul (
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	assign weighed = mul_p[SPT_W+VOL_W-1:SPT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= '0;
		end else if (cfg_we) begin
			spt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			partial_q   <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (short_span) begin
						partial_q <= partial_q + weighed;
						phase_q   <= phase_q + span_q[SPT_W-1:0];
						state_q   <= S_IDLE;
					end else if (out_free) begin
						state_q     <= (left[SPAN_W-1:SPT_W] == '0) ? S_FRAC : S_WHOLE;
					end
				end
				S_WHOLE: begin
					if (out_free) begin
						if (whole_q == TICK_W'(1)) begin
							state_q <= S_FRAC;
						end
					end
				end
				S_FRAC: begin
					partial_q <= weighed;
					phase_q   <= frac_q;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			vol_q   <= level_to_vol(in_data.level_a, in_data.level_b, in_data.level_c);
			ticks_q <= ticks_sat;
		end
		if (state_q == S_SPAN) begin
			span_q <= mul_p[SPAN_W-1:0];
		end
		if (state_q == S_SPLIT && !short_span && out_free) begin
			out_q.sample <= partial_q + weighed;
			out_q.last   <= (left[SPAN_W-1:SPT_W] == '0);
			whole_q      <= left[SPAN_W-1:SPT_W];
			frac_q       <= left[SPT_W-1:0];
		end
		if (state_q == S_WHOLE && out_free) begin
			out_q.sample <= vol_q;
			out_q.last   <= (whole_q == TICK_W'(1));
			whole_q      <= whole_q - TICK_W'(1);
		end
	end

	a_whole_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WHOLE |-> whole_q != '0)
		else $error("whole-sample count empty while emitting whole samples");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> state_q == S_WHOLE)
		else $error("non-final sample pending without further samples to come");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_SPAN)
		else $error("accepted beat did not start the span multiply");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(phase_q))
		else $error("phase changed while idle");

endmodule
